// ===== sv/chunk_digest_dedup_filter_assert.svh =====
`ifndef CHUNK_DIGEST_DEDUP_FILTER_ASSERT_SVH
`define CHUNK_DIGEST_DEDUP_FILTER_ASSERT_SVH

// check cons in the same cycle as ante
`define CDDF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cddf assertion failed");

// check cons in the cycle after ante
`define CDDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cddf assertion failed");

`endif

// ===== sv/cddf_pkg.sv =====
package cddf_pkg;

   localparam int PRIOR_DEPTH   = 1024;
   localparam int CURRENT_DEPTH = 1024;
   localparam int DIGEST_BITS   = 160;

   localparam int DIGEST_FIELD_BITS = 160;
   localparam int CMD_BITS          = 2;
   localparam int CHUNK_BITS        = 16;
   localparam int COUNT_BITS        = 11;
   localparam int COUNT_MAX         = 2047;
   localparam int REQ_TDATA_BITS    = 176;
   localparam int RSP_TDATA_BITS    = 32;

   localparam logic [CMD_BITS-1:0] CMD_CLEAR_PRIOR  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_PRIOR   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_START_REGION = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_CHECK_CHUNK  = 2'd3;

   typedef struct packed {
      logic load;
      logic scan_en;
      logic scan_sel;
      logic scan_clr;
      logic mark_prior;
      logic mark_cur;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic                hit;
      logic                scan_done;
      logic                out_free;
      logic [CMD_BITS-1:0] item_cmd;
   } ctl_status_type;

endpackage

// ===== sv/cddf_ctrl.sv =====
module cddf_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cddf_pkg::CMD_BITS-1:0]   req_tuser,
   output cddf_pkg::ctl_cmd_type           ctl,
   input  cddf_pkg::ctl_status_type        sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PSCAN  = 2'd1;
   localparam logic [1:0] ST_CSCAN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load     = 1'b1;
               ctl.scan_clr = 1'b1;
               if (req_tuser == cddf_pkg::CMD_LOAD_PRIOR ||
                   req_tuser == cddf_pkg::CMD_CHECK_CHUNK) begin
                  state_in = ST_PSCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PSCAN: begin
            ctl.scan_en  = 1'b1;
            ctl.scan_sel = 1'b0;
            if (sts.hit) begin
               ctl.mark_prior = 1'b1;
               state_in       = ST_FINISH;
            end else if (sts.scan_done) begin
               if (sts.item_cmd == cddf_pkg::CMD_CHECK_CHUNK) begin
                  ctl.scan_clr = 1'b1;
                  state_in     = ST_CSCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_CSCAN: begin
            ctl.scan_en  = 1'b1;
            ctl.scan_sel = 1'b1;
            if (sts.hit) begin
               ctl.mark_cur = 1'b1;
               state_in     = ST_FINISH;
            end else if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               ctl.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/cddf_datapath.sv =====
module cddf_datapath #(
   parameter int PRIOR_DEPTH   = cddf_pkg::PRIOR_DEPTH,
   parameter int CURRENT_DEPTH = cddf_pkg::CURRENT_DEPTH,
   parameter int DIGEST_BITS   = cddf_pkg::DIGEST_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [cddf_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  logic [cddf_pkg::CMD_BITS-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [cddf_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   input  cddf_pkg::ctl_cmd_type                 ctl,
   output cddf_pkg::ctl_status_type              sts
);

   localparam int KEY_BITS = (DIGEST_BITS < cddf_pkg::DIGEST_FIELD_BITS) ?
                             DIGEST_BITS : cddf_pkg::DIGEST_FIELD_BITS;
   localparam int PAW = $clog2(PRIOR_DEPTH);
   localparam int CAW = $clog2(CURRENT_DEPTH);
   localparam int PFW = $clog2(PRIOR_DEPTH + 1);
   localparam int CFW = $clog2(CURRENT_DEPTH + 1);
   localparam int IW  = (PFW > CFW) ? PFW : CFW;

   logic [KEY_BITS-1:0]                  prior_mem [PRIOR_DEPTH];
   logic [KEY_BITS-1:0]                  cur_mem [CURRENT_DEPTH];
   logic [KEY_BITS-1:0]                  prior_q_ff;
   logic [KEY_BITS-1:0]                  cur_q_ff;

   logic [cddf_pkg::DIGEST_FIELD_BITS-1:0] digest_all;
   logic [KEY_BITS-1:0]                  key_ff;
   logic [cddf_pkg::CHUNK_BITS-1:0]      chunk_ff;
   logic [cddf_pkg::CMD_BITS-1:0]        cmd_ff;
   logic                                 prior_hit_ff;
   logic                                 cur_hit_ff;
   logic [PFW-1:0]                       prior_fill_ff;
   logic [PFW-1:0]                       prior_fill_in;
   logic [CFW-1:0]                       cur_fill_ff;
   logic [CFW-1:0]                       cur_fill_in;
   logic [IW-1:0]                        idx_ff;
   logic                                 pend_ff;
   logic [IW-1:0]                        fill_sel;
   logic                                 issue;
   logic                                 prior_we;
   logic                                 cur_we;
   logic                                 is_new;
   logic                                 seen;
   logic                                 status;
   logic [cddf_pkg::COUNT_BITS-1:0]      unique_count;
   logic                                 rsp_valid_ff;
   logic [cddf_pkg::RSP_TDATA_BITS-1:0]  rsp_data_ff;

   assign digest_all = req_tdata[cddf_pkg::DIGEST_FIELD_BITS-1:0];

   assign fill_sel = ctl.scan_sel ? IW'(cur_fill_ff) : IW'(prior_fill_ff);
   assign issue    = ctl.scan_en && (idx_ff < fill_sel);

   assign sts.hit       = ctl.scan_en && pend_ff &&
                          (ctl.scan_sel ? (cur_q_ff == key_ff) : (prior_q_ff == key_ff));
   assign sts.scan_done = ctl.scan_en && !issue && !pend_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;
   assign sts.item_cmd  = cmd_ff;

   always_comb begin
      prior_fill_in = prior_fill_ff;
      cur_fill_in   = cur_fill_ff;
      prior_we      = 1'b0;
      cur_we        = 1'b0;
      is_new        = 1'b0;
      seen          = 1'b0;
      status        = 1'b0;
      case (cmd_ff)
         cddf_pkg::CMD_CLEAR_PRIOR: begin
            prior_fill_in = '0;
         end
         cddf_pkg::CMD_LOAD_PRIOR: begin
            if (!prior_hit_ff) begin
               if (prior_fill_ff < PFW'(PRIOR_DEPTH)) begin
                  prior_we      = 1'b1;
                  prior_fill_in = prior_fill_ff + 1'b1;
               end else begin
                  status = 1'b1;
               end
            end
         end
         cddf_pkg::CMD_START_REGION: begin
            cur_fill_in = '0;
         end
         cddf_pkg::CMD_CHECK_CHUNK: begin
            if (prior_hit_ff) begin
               seen = 1'b1;
            end else if (!cur_hit_ff) begin
               if (cur_fill_ff < CFW'(CURRENT_DEPTH)) begin
                  cur_we      = 1'b1;
                  cur_fill_in = cur_fill_ff + 1'b1;
                  is_new      = 1'b1;
               end else begin
                  status = 1'b1;
               end
            end
         end
         default: begin
            status = 1'b0;
         end
      endcase
      if (32'(cur_fill_in) > cddf_pkg::COUNT_MAX) begin
         unique_count = cddf_pkg::COUNT_BITS'(cddf_pkg::COUNT_MAX);
      end else begin
         unique_count = cddf_pkg::COUNT_BITS'(cur_fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit && prior_we) begin
         prior_mem[prior_fill_ff[PAW-1:0]] <= key_ff;
      end else if (issue && !ctl.scan_sel) begin
         prior_q_ff <= prior_mem[idx_ff[PAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit && cur_we) begin
         cur_mem[cur_fill_ff[CAW-1:0]] <= key_ff;
      end else if (issue && ctl.scan_sel) begin
         cur_q_ff <= cur_mem[idx_ff[CAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff   <= digest_all[KEY_BITS-1:0];
         chunk_ff <= req_tdata[cddf_pkg::DIGEST_FIELD_BITS +: cddf_pkg::CHUNK_BITS];
         cmd_ff   <= req_tuser;
      end
      if (ctl.commit) begin
         rsp_data_ff <= {2'b00, status, unique_count, chunk_ff, seen, is_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_fill_ff <= '0;
         cur_fill_ff   <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         prior_hit_ff  <= 1'b0;
         cur_hit_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ctl.scan_clr) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
         end else begin
            if (issue) begin
               idx_ff <= idx_ff + 1'b1;
            end
            pend_ff <= issue;
         end
         if (ctl.load) begin
            prior_hit_ff <= 1'b0;
            cur_hit_ff   <= 1'b0;
         end else begin
            if (ctl.mark_prior) begin
               prior_hit_ff <= 1'b1;
            end
            if (ctl.mark_cur) begin
               cur_hit_ff <= 1'b1;
            end
         end
         if (ctl.commit) begin
            prior_fill_ff <= prior_fill_in;
            cur_fill_ff   <= cur_fill_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/chunk_digest_dedup_filter.sv =====
// Chunk digest dedup filter. Each req beat carries a command in tuser: clear the prior
// table, load one prior digest, start a region (clear the current table), or check a
// chunk digest; every command returns exactly one rsp beat with is_new, seen_before, the
// echoed chunk number, the unique count of the region and a table-full status. Both
// tables are single-port memories searched one entry per cycle; a check searches the
// prior table and then the current table, a prior load searches only the prior table, a
// hit ends the search early, and a clear or region start searches neither; one command
// is in work at a time, and the next is taken while the last result still waits in the
// output register. No clearing pass runs after reset.
module chunk_digest_dedup_filter #(
   parameter int PRIOR_DEPTH   = cddf_pkg::PRIOR_DEPTH,
   parameter int CURRENT_DEPTH = cddf_pkg::CURRENT_DEPTH,
   parameter int DIGEST_BITS   = cddf_pkg::DIGEST_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // digest_low, digest_middle, digest_high, chunk_number
   input  logic [cddf_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // cmd
   input  logic [cddf_pkg::CMD_BITS-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // is_new, seen_before, echo_chunk, unique_count, status, zero pad
   output logic [cddf_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata
);

   cddf_pkg::ctl_cmd_type    ctl;
   cddf_pkg::ctl_status_type sts;

   cddf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .ctl        (ctl),
      .sts        (sts)
   );

   cddf_datapath #(
      .PRIOR_DEPTH   (PRIOR_DEPTH),
      .CURRENT_DEPTH (CURRENT_DEPTH),
      .DIGEST_BITS   (DIGEST_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .sts        (sts)
   );

endmodule

// ===== sv/cddf_checker.sv =====
`include "chunk_digest_dedup_filter_assert.svh"

module cddf_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [cddf_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input logic [cddf_pkg::CMD_BITS-1:0]         req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [cddf_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata
);

   `CDDF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CDDF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `CDDF_ASSERT_SAME(a_new_not_seen, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]))
   `CDDF_ASSERT_SAME(a_new_not_full, clock, reset, rsp_tvalid && rsp_tdata[0], !rsp_tdata[29])
   `CDDF_ASSERT_SAME(a_seen_not_full, clock, reset, rsp_tvalid && rsp_tdata[1], !rsp_tdata[29])

endmodule

bind chunk_digest_dedup_filter cddf_checker u_cddf_checker (.*);
